// File: hw/rtl/dpt_pkg.sv
package dpt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DEPTH_W    = 16;
    localparam int OUT_W      = 21;

    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd7;

    typedef struct packed {
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic [23:0]        inv_fx;
        logic [23:0]        inv_fy;
        logic [2:0][47:0]   rot;
        logic [2:0][15:0]   trans;
        logic [DEPTH_W-1:0] max_depth;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cx:        16'h13F9,
        cy:        16'h0F05,
        inv_fx:    24'd43621,
        inv_fy:    24'd43621,
        rot:       {48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000},
        trans:     '0,
        max_depth: 16'd3000
    };

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// File: hw/rtl/dpt_backproj.sv
module dpt_backproj #(
    parameter int PIXEL_INDEX_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dpt_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [PIXEL_INDEX_BITS-1:0]           i_pixel_row,
    input  logic [PIXEL_INDEX_BITS-1:0]           i_pixel_col,
    input  logic [dpt_pkg::DEPTH_W-1:0]           i_depth_mm,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [((PIXEL_INDEX_BITS+4 > 16) ? PIXEL_INDEX_BITS+4 : 16)+20:0] o_xc,
    output logic signed [((PIXEL_INDEX_BITS+4 > 16) ? PIXEL_INDEX_BITS+4 : 16)+20:0] o_yc,
    output logic [dpt_pkg::DEPTH_W-1:0]           o_z
);

    localparam int CW = PIXEL_INDEX_BITS + 4;
    localparam int DW = ((CW > 16) ? CW : 16) + 1;
    localparam int MW = DW + 24;
    localparam int PW = MW + dpt_pkg::DEPTH_W;
    localparam int XW = PW - 20;

    logic r_vld1, r_vld2, r_vld3, r_vld4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [MW-1:0] r_mx, r_my;
    logic signed [PW-1:0] r_px, r_py;
    logic signed [XW-1:0] r_xc, r_yc;
    logic [dpt_pkg::DEPTH_W-1:0] r_z1, r_z2, r_z3, r_z4;

    logic                 w_keep;
    logic signed [DW-1:0] w_dx, w_dy;
    logic signed [MW-1:0] w_mx, w_my;
    logic signed [PW-1:0] w_px, w_py;
    logic signed [PW-1:0] w_rx, w_ry;

    assign w_rdy4  = !r_vld4 || i_ready;
    assign w_rdy3  = !r_vld3 || w_rdy4;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_keep = (i_depth_mm != '0) && (i_depth_mm <= i_cfg.max_depth);

    // pixel offsets from the principal point, 4 fraction bits
    assign w_dx = {{(DW-CW){1'b0}}, i_pixel_col, 4'b0} - {{(DW-16){1'b0}}, i_cfg.cx};
    assign w_dy = {{(DW-CW){1'b0}}, i_pixel_row, 4'b0} - {{(DW-16){1'b0}}, i_cfg.cy};

    assign w_mx = $signed({{(MW-DW){r_dx[DW-1]}}, r_dx})
                * $signed({{(MW-24){1'b0}}, i_cfg.inv_fx});
    assign w_my = $signed({{(MW-DW){r_dy[DW-1]}}, r_dy})
                * $signed({{(MW-24){1'b0}}, i_cfg.inv_fy});

    assign w_px = $signed({{(PW-MW){r_mx[MW-1]}}, r_mx})
                * $signed({{(PW-dpt_pkg::DEPTH_W){1'b0}}, r_z2});
    assign w_py = $signed({{(PW-MW){r_my[MW-1]}}, r_my})
                * $signed({{(PW-dpt_pkg::DEPTH_W){1'b0}}, r_z2});

    // round half away from zero, drop 20 fraction bits
    assign w_rx = r_px + {{(PW-20){1'b0}}, 1'b1, 19'b0} - {{(PW-1){1'b0}}, r_px[PW-1]};
    assign w_ry = r_py + {{(PW-20){1'b0}}, 1'b1, 19'b0} - {{(PW-1){1'b0}}, r_py[PW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid && w_keep;
            if (w_rdy2) r_vld2 <= r_vld1;
            if (w_rdy3) r_vld3 <= r_vld2;
            if (w_rdy4) r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_dx <= w_dx;
            r_dy <= w_dy;
            r_z1 <= i_depth_mm;
        end
        if (w_rdy2) begin
            r_mx <= w_mx;
            r_my <= w_my;
            r_z2 <= r_z1;
        end
        if (w_rdy3) begin
            r_px <= w_px;
            r_py <= w_py;
            r_z3 <= r_z2;
        end
        if (w_rdy4) begin
            r_xc <= w_rx[PW-1:20];
            r_yc <= w_ry[PW-1:20];
            r_z4 <= r_z3;
        end
    end

    assign o_valid = r_vld4;
    assign o_xc    = r_xc;
    assign o_yc    = r_yc;
    assign o_z     = r_z4;

endmodule

// File: hw/rtl/dpt_rigid.sv
module dpt_rigid #(
    parameter int PIXEL_INDEX_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dpt_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [((PIXEL_INDEX_BITS+4 > 16) ? PIXEL_INDEX_BITS+4 : 16)+20:0] i_xc,
    input  logic signed [((PIXEL_INDEX_BITS+4 > 16) ? PIXEL_INDEX_BITS+4 : 16)+20:0] i_yc,
    input  logic [dpt_pkg::DEPTH_W-1:0]           i_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [dpt_pkg::OUT_W-1:0]      o_point_x,
    output logic signed [dpt_pkg::OUT_W-1:0]      o_point_y,
    output logic signed [dpt_pkg::OUT_W-1:0]      o_point_z
);

    localparam int CW = PIXEL_INDEX_BITS + 4;
    localparam int XW = ((CW > 16) ? CW : 16) + 21;
    localparam int QW = XW + 16;
    localparam int AW = QW + 2;
    localparam int SW = AW - 22;
    localparam int OW = dpt_pkg::OUT_W;

    logic r_vld5, r_vld6, r_vld7;
    logic w_rdy5, w_rdy6, w_rdy7;

    logic signed [QW-1:0] w_op   [3];
    logic signed [QW-1:0] w_prod [3][3];
    logic signed [QW-1:0] r_prod [3][3];
    logic signed [AW-1:0] w_acc  [3];
    logic signed [AW-1:0] r_acc  [3];
    logic signed [AW-1:0] w_rnd  [3];
    logic signed [OW-1:0] w_sat  [3];
    logic signed [OW-1:0] r_out  [3];

    assign w_rdy7  = !r_vld7 || i_ready;
    assign w_rdy6  = !r_vld6 || w_rdy7;
    assign w_rdy5  = !r_vld5 || w_rdy6;
    assign o_ready = w_rdy5;

    assign w_op[0] = {{(QW-XW){i_xc[XW-1]}}, i_xc};
    assign w_op[1] = {{(QW-XW){i_yc[XW-1]}}, i_yc};
    assign w_op[2] = {{(QW-dpt_pkg::DEPTH_W-8){1'b0}}, i_z, 8'b0};

    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        logic [SW-1:0] w_sh;
        logic          w_fits;

        for (genvar gk = 0; gk < 3; gk++) begin : g_col
            assign w_prod[gr][gk] = $signed(w_op[gk])
                * $signed({{(QW-16){i_cfg.rot[gr][16*gk+15]}}, i_cfg.rot[gr][16*gk +: 16]});
        end

        assign w_acc[gr] = {{(AW-QW){r_prod[gr][0][QW-1]}}, r_prod[gr][0]}
                         + {{(AW-QW){r_prod[gr][1][QW-1]}}, r_prod[gr][1]}
                         + {{(AW-QW){r_prod[gr][2][QW-1]}}, r_prod[gr][2]}
                         + {{(AW-38){i_cfg.trans[gr][15]}}, i_cfg.trans[gr], 22'b0};

        // round half away from zero, drop 22 fraction bits, then clamp
        assign w_rnd[gr] = r_acc[gr] + {{(AW-22){1'b0}}, 1'b1, 21'b0}
                         - {{(AW-1){1'b0}}, r_acc[gr][AW-1]};
        assign w_sh      = w_rnd[gr][AW-1:22];
        assign w_fits    = (&w_sh[SW-1:OW-1]) || !(|w_sh[SW-1:OW-1]);
        assign w_sat[gr] = w_fits ? w_sh[OW-1:0]
                         : (w_sh[SW-1] ? dpt_pkg::OUT_MIN : dpt_pkg::OUT_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else begin
            if (w_rdy5) r_vld5 <= i_valid;
            if (w_rdy6) r_vld6 <= r_vld5;
            if (w_rdy7) r_vld7 <= r_vld6;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            if (w_rdy5) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[r][k] <= w_prod[r][k];
                end
            end
            if (w_rdy6) r_acc[r] <= w_acc[r];
            if (w_rdy7) r_out[r] <= w_sat[r];
        end
    end

    assign o_valid   = r_vld7;
    assign o_point_x = r_out[0];
    assign o_point_y = r_out[1];
    assign o_point_z = r_out[2];

endmodule

// File: hw/rtl/depth_pixel_to_point_transform_top.sv
// The pipeline has 4 back-projection stages followed by 3 transform stages.
// Throughput: one pixel per cycle while the sink is ready; each stage stalls only while
// it holds data and the stage after it is full, so bubbles are squeezed out.
// Pixels with zero depth or depth above max_depth are dropped at the first stage.
// Reset (synchronous, active low) empties the pipeline and loads the default camera setup.
module depth_pixel_to_point_transform_top #(
    parameter int PIXEL_INDEX_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dpt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dpt_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [PIXEL_INDEX_BITS-1:0]           i_pixel_row,
    input  logic [PIXEL_INDEX_BITS-1:0]           i_pixel_col,
    input  logic [dpt_pkg::DEPTH_W-1:0]           i_depth_mm,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [dpt_pkg::OUT_W-1:0]      o_point_x,
    output logic signed [dpt_pkg::OUT_W-1:0]      o_point_y,
    output logic signed [dpt_pkg::OUT_W-1:0]      o_point_z
);

    localparam int CW = PIXEL_INDEX_BITS + 4;
    localparam int XW = ((CW > 16) ? CW : 16) + 21;

    dpt_pkg::t_cfg r_cfg;

    logic                        w_bp_valid;
    logic                        w_bp_ready;
    logic signed [XW-1:0]        w_xc;
    logic signed [XW-1:0]        w_yc;
    logic [dpt_pkg::DEPTH_W-1:0] w_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= dpt_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpt_pkg::REG_PRINCIPAL: begin
                    r_cfg.cx <= i_cfg_wdata[15:0];
                    r_cfg.cy <= i_cfg_wdata[31:16];
                end
                dpt_pkg::REG_INV_FX:    r_cfg.inv_fx    <= i_cfg_wdata[23:0];
                dpt_pkg::REG_INV_FY:    r_cfg.inv_fy    <= i_cfg_wdata[23:0];
                dpt_pkg::REG_ROT_X:     r_cfg.rot[0]    <= i_cfg_wdata;
                dpt_pkg::REG_ROT_Y:     r_cfg.rot[1]    <= i_cfg_wdata;
                dpt_pkg::REG_ROT_Z:     r_cfg.rot[2]    <= i_cfg_wdata;
                dpt_pkg::REG_TRANS:     r_cfg.trans     <= i_cfg_wdata;
                dpt_pkg::REG_MAX_DEPTH: r_cfg.max_depth <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    dpt_backproj #(
        .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS)
    ) u_backproj (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_row(i_pixel_row),
        .i_pixel_col(i_pixel_col),
        .i_depth_mm (i_depth_mm),
        .o_valid    (w_bp_valid),
        .i_ready    (w_bp_ready),
        .o_xc       (w_xc),
        .o_yc       (w_yc),
        .o_z        (w_z)
    );

    dpt_rigid #(
        .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS)
    ) u_rigid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_bp_valid),
        .o_ready  (w_bp_ready),
        .i_xc     (w_xc),
        .i_yc     (w_yc),
        .i_z      (w_z),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_point_x(o_point_x),
        .o_point_y(o_point_y),
        .o_point_z(o_point_z)
    );

    // backpressure only when every stage is full and the sink stalls
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && !w_bp_ready))
        else $error("input stalled while pipeline has room");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // internal hand-off between the two halves holds its beat while stalled
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bp_valid && !w_bp_ready) |=>
            (w_bp_valid && $stable(w_xc) && $stable(w_yc) && $stable(w_z)))
        else $error("mid-pipeline beat changed under stall");

    a_no_stall_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ready || !o_valid) |-> w_bp_ready)
        else $error("transform stage stalled with open output");

endmodule

// File: sim/tb_depth_pixel_to_point_transform_top.sv
module tb_depth_pixel_to_point_transform_top;

    localparam int PIX_W       = 12;
    localparam int DRAIN_WAIT  = 12;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct {
        logic signed [dpt_pkg::OUT_W-1:0] x;
        logic signed [dpt_pkg::OUT_W-1:0] y;
        logic signed [dpt_pkg::OUT_W-1:0] z;
    } t_point;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [dpt_pkg::CFG_IDX_W-1:0]  i_cfg_index = dpt_pkg::REG_PRINCIPAL;
    logic [dpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [PIX_W-1:0]               i_pixel_row = '0;
    logic [PIX_W-1:0]               i_pixel_col = '0;
    logic [dpt_pkg::DEPTH_W-1:0]    i_depth_mm = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b1;
    logic signed [dpt_pkg::OUT_W-1:0] o_point_x;
    logic signed [dpt_pkg::OUT_W-1:0] o_point_y;
    logic signed [dpt_pkg::OUT_W-1:0] o_point_z;

    logic [dpt_pkg::CFG_DATA_W-1:0] cfg_shadow [8];
    t_point                pending_points [$];
    t_point                got_pt;
    int                    err_count = 0;
    int                    idle_cycles = 0;
    bit                    source_gaps = 1'b0;
    bit                    sink_stalls = 1'b0;

    depth_pixel_to_point_transform_top #(
        .PIXEL_INDEX_BITS(PIX_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_row(i_pixel_row),
        .i_pixel_col(i_pixel_col),
        .i_depth_mm (i_depth_mm),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_point_z  (o_point_z)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [dpt_pkg::CFG_DATA_W-1:0] reg_mask(
            input logic [dpt_pkg::CFG_IDX_W-1:0] idx);
        case (idx)
            dpt_pkg::REG_PRINCIPAL: return 48'h0000_FFFF_FFFF;
            dpt_pkg::REG_INV_FX,
            dpt_pkg::REG_INV_FY:    return 48'h0000_00FF_FFFF;
            dpt_pkg::REG_MAX_DEPTH: return 48'h0000_0000_FFFF;
            default:                return 48'hFFFF_FFFF_FFFF;
        endcase
    endfunction

    function automatic longint round_half_away(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    function automatic logic signed [dpt_pkg::OUT_W-1:0] rotate_axis(input logic [47:0] coefs,
                                                            input longint xc, input longint yc,
                                                            input longint zc,
                                                            input logic [15:0] offset);
        logic signed [15:0] c0, c1, c2, t;
        longint acc;
        c0 = coefs[15:0];
        c1 = coefs[31:16];
        c2 = coefs[47:32];
        t  = offset;
        acc = longint'(c0) * xc + longint'(c1) * yc + longint'(c2) * zc
            + longint'(t) * 64'sd4194304;
        acc = round_half_away(acc, 22);
        if (acc > 64'sd1048575) acc = 64'sd1048575;
        if (acc < -64'sd1048576) acc = -64'sd1048576;
        return acc[dpt_pkg::OUT_W-1:0];
    endfunction

    // returns 0 when the depth sample is rejected
    function automatic bit backproject_point(input logic [PIX_W-1:0] row,
                                             input logic [PIX_W-1:0] col,
                                             input logic [dpt_pkg::DEPTH_W-1:0] depth,
                                             output t_point p);
        longint z, dx, dy, xc, yc, zc;
        logic [47:0] tr;
        tr = cfg_shadow[dpt_pkg::REG_TRANS];
        if (depth == 0 || depth > cfg_shadow[dpt_pkg::REG_MAX_DEPTH][15:0]) return 1'b0;
        z  = longint'(depth);
        dx = longint'({col, 4'b0}) - longint'(cfg_shadow[dpt_pkg::REG_PRINCIPAL][15:0]);
        dy = longint'({row, 4'b0}) - longint'(cfg_shadow[dpt_pkg::REG_PRINCIPAL][31:16]);
        xc = round_half_away(dx * longint'(cfg_shadow[dpt_pkg::REG_INV_FX][23:0]) * z, 20);
        yc = round_half_away(dy * longint'(cfg_shadow[dpt_pkg::REG_INV_FY][23:0]) * z, 20);
        zc = z * 256;
        p.x = rotate_axis(cfg_shadow[dpt_pkg::REG_ROT_X], xc, yc, zc, tr[15:0]);
        p.y = rotate_axis(cfg_shadow[dpt_pkg::REG_ROT_Y], xc, yc, zc, tr[31:16]);
        p.z = rotate_axis(cfg_shadow[dpt_pkg::REG_ROT_Z], xc, yc, zc, tr[47:32]);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic cfg_write(input logic [dpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpt_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        cfg_shadow[idx] = data & reg_mask(idx);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col,
                              input logic [dpt_pkg::DEPTH_W-1:0] depth);
        int gap;
        t_point p;
        gap = (source_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_pixel_row = row;
        i_pixel_col = col;
        i_depth_mm  = depth;
        do @(posedge i_clk); while (!o_ready);
        if (backproject_point(row, col, depth, p)) begin
            pending_points.insert(pending_points.size(), p);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        int r;
        logic [15:0] dmax;
        logic [dpt_pkg::DEPTH_W-1:0] depth;
        logic [PIX_W-1:0] row, col;
        dmax = cfg_shadow[dpt_pkg::REG_MAX_DEPTH][15:0];
        r = $urandom_range(0, 99);
        if (r < 5) depth = '0;
        else if (r < 12) depth = (dmax == 16'hFFFF) ? 16'hFFFF
                                                    : 16'($urandom_range(dmax + 1, 65535));
        else if (r < 17 || dmax == 0) depth = dmax;
        else depth = 16'($urandom_range(1, dmax));
        if ($urandom_range(0, 9) < 7) begin
            row = PIX_W'($urandom_range(0, 959));
            col = PIX_W'($urandom_range(0, 1279));
        end else begin
            row = PIX_W'($urandom_range(0, 4095));
            col = PIX_W'($urandom_range(0, 4095));
        end
        send_pixel(row, col, depth);
    endtask

    function automatic logic [47:0] rot_row(input int axis, input bit neg);
        logic [47:0] coefs;
        int val;
        for (int k = 0; k < 3; k++) begin
            val = $urandom_range(0, 255);
            val = val - 128;
            if (k == axis) val += neg ? -16384 : 16384;
            coefs[16*k +: 16] = 16'(val);
        end
        return coefs;
    endfunction

    task automatic plausible_setup();
        int shift, val;
        logic [47:0] tr;
        shift = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            val = $urandom_range(0, 6000);
            tr[16*k +: 16] = 16'(val - 3000);
        end
        cfg_write(dpt_pkg::REG_PRINCIPAL, {16'd0, 16'($urandom_range(0, 960 * 16)),
                                           16'($urandom_range(0, 1280 * 16))});
        cfg_write(dpt_pkg::REG_INV_FX, 48'((1 << 24) / $urandom_range(150, 1500)));
        cfg_write(dpt_pkg::REG_INV_FY, 48'((1 << 24) / $urandom_range(150, 1500)));
        cfg_write(dpt_pkg::REG_ROT_X, rot_row(shift, 1'($urandom_range(0, 1))));
        cfg_write(dpt_pkg::REG_ROT_Y, rot_row((shift + 1) % 3, 1'($urandom_range(0, 1))));
        cfg_write(dpt_pkg::REG_ROT_Z, rot_row((shift + 2) % 3, 1'($urandom_range(0, 1))));
        cfg_write(dpt_pkg::REG_TRANS, tr);
        cfg_write(dpt_pkg::REG_MAX_DEPTH, ($urandom_range(0, 3) == 0) ? 48'd65535
                                                    : 48'($urandom_range(500, 10000)));
    endtask

    task automatic wild_setup();
        cfg_write(dpt_pkg::REG_PRINCIPAL, {16'($urandom()), 32'($urandom())});
        cfg_write(dpt_pkg::REG_INV_FX,    {16'($urandom()), 32'($urandom())});
        cfg_write(dpt_pkg::REG_INV_FY,    {16'($urandom()), 32'($urandom())});
        cfg_write(dpt_pkg::REG_ROT_X,     {16'($urandom()), 32'($urandom())});
        cfg_write(dpt_pkg::REG_ROT_Y,     {16'($urandom()), 32'($urandom())});
        cfg_write(dpt_pkg::REG_ROT_Z,     {16'($urandom()), 32'($urandom())});
        cfg_write(dpt_pkg::REG_TRANS,     {16'($urandom()), 32'($urandom())});
        cfg_write(dpt_pkg::REG_MAX_DEPTH, {16'($urandom()), 32'($urandom())});
    endtask

    task automatic test_default_setup();
        send_pixel(12'd240, 12'd320, 16'd1000);
        send_pixel(12'd0, 12'd0, 16'd1);
        send_pixel(12'd4095, 12'd4095, 16'd3000);
        send_pixel(12'd0, 12'd4095, 16'd3000);
        send_pixel(12'd4095, 12'd0, 16'd2999);
        // rejected depths
        send_pixel(12'd100, 12'd200, 16'd0);
        send_pixel(12'd100, 12'd200, 16'd3001);
        send_pixel(12'd120, 12'd640, 16'd65535);
        wait_drained();
    endtask

    task automatic test_extreme_setup();
        // principal point beyond the image, full-scale focal, saturating transform
        cfg_write(dpt_pkg::REG_PRINCIPAL, 48'hFFFF_FFFF_FFFF);
        cfg_write(dpt_pkg::REG_INV_FX, 48'hFFFF_FFFF_FFFF);
        cfg_write(dpt_pkg::REG_INV_FY, 48'h0000_00FF_FFFF);
        cfg_write(dpt_pkg::REG_ROT_X, 48'h7FFF_7FFF_7FFF);
        cfg_write(dpt_pkg::REG_ROT_Y, 48'h8000_8000_8000);
        cfg_write(dpt_pkg::REG_ROT_Z, 48'h7FFF_8000_0001);
        cfg_write(dpt_pkg::REG_TRANS, 48'h0000_8000_7FFF);
        cfg_write(dpt_pkg::REG_MAX_DEPTH, 48'h0000_0000_FFFF);
        send_pixel(12'd0, 12'd0, 16'hFFFF);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 16'd1);
        send_pixel(12'd4095, 12'd0, 16'h8000);
        wait_drained();
        cfg_write(dpt_pkg::REG_PRINCIPAL, 48'd0);
        cfg_write(dpt_pkg::REG_INV_FX, 48'd0);
        cfg_write(dpt_pkg::REG_INV_FY, 48'd0);
        cfg_write(dpt_pkg::REG_ROT_X, 48'h0000_0000_4000);
        cfg_write(dpt_pkg::REG_ROT_Y, 48'h0000_4000_0000);
        cfg_write(dpt_pkg::REG_ROT_Z, 48'h4000_0000_0000);
        cfg_write(dpt_pkg::REG_TRANS, 48'h7FFF_8000_FFFF);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF);
        send_pixel(12'd1, 12'd2, 16'd7);
        wait_drained();
        // zero max depth rejects everything
        cfg_write(dpt_pkg::REG_MAX_DEPTH, 48'd0);
        send_pixel(12'd10, 12'd10, 16'd1);
        send_pixel(12'd0, 12'd0, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_random_setups();
        for (int ph = 0; ph < 6; ph++) begin
            source_gaps = (ph != 1) && (ph != 3);
            sink_stalls = (ph != 1) && (ph != 4);
            if (ph == 2 || ph == 4) wild_setup();
            else plausible_setup();
            for (int n = 0; n < 200; n++) begin
                if (n == 100) wait_drained();
                send_random_pixel();
            end
            wait_drained();
        end
    endtask

    task automatic test_full_rate();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        plausible_setup();
        cfg_write(dpt_pkg::REG_MAX_DEPTH, 48'd65535);
        repeat (150) send_random_pixel();
        wait_drained();
    endtask

    initial begin
        int n;
        forever begin
            if (!sink_stalls) begin
                i_ready = 1'b1;
                @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge i_clk);
                i_ready = 1'b0;
                n = pick_gap();
                repeat (n) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected point: x %0d y %0d z %0d", o_point_x, o_point_y, o_point_z);
                err_count++;
            end else begin
                got_pt = pending_points.pop_front();
                if (o_point_x !== got_pt.x) begin
                    $error("point_x mismatch: expected %0d, got %0d", got_pt.x, o_point_x);
                    err_count++;
                end
                if (o_point_y !== got_pt.y) begin
                    $error("point_y mismatch: expected %0d, got %0d", got_pt.y, o_point_y);
                    err_count++;
                end
                if (o_point_z !== got_pt.z) begin
                    $error("point_z mismatch: expected %0d, got %0d", got_pt.z, o_point_z);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        cfg_shadow[dpt_pkg::REG_PRINCIPAL] = 48'h0000_0F05_13F9;
        cfg_shadow[dpt_pkg::REG_INV_FX]    = 48'd43621;
        cfg_shadow[dpt_pkg::REG_INV_FY]    = 48'd43621;
        cfg_shadow[dpt_pkg::REG_ROT_X]     = 48'h0000_0000_4000;
        cfg_shadow[dpt_pkg::REG_ROT_Y]     = 48'h0000_4000_0000;
        cfg_shadow[dpt_pkg::REG_ROT_Z]     = 48'h4000_0000_0000;
        cfg_shadow[dpt_pkg::REG_TRANS]     = 48'd0;
        cfg_shadow[dpt_pkg::REG_MAX_DEPTH] = 48'd3000;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_setup();
        test_extreme_setup();
        test_random_setups();
        test_full_rate();

        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
